// ----- sv/emn_pkg.sv -----
// ----------------------------------------------------------------------------
// emn_pkg
// Shared types, command codes and the quadrature decode table for the
// encoder menu navigator.
// ----------------------------------------------------------------------------
package emn_pkg;

  localparam int unsigned RowsW  = 16;
  localparam int unsigned LinesW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic [1:0] {
    CMD_ENC   = 2'd0,
    CMD_UP    = 2'd1,
    CMD_DOWN  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_COUNT  = 2'd0,
    REG_LINE_COUNT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e command;
    logic enc_a;
    logic enc_b;
  } in_item_t;

  typedef struct packed {
    logic [15:0] selected_line;
    logic [15:0] first_line;
    logic        position_changed;
  } out_item_t;

  // navigation state carried between items
  typedef struct packed {
    logic [1:0]       prev_ab;
    logic             parity;
    logic [RowsW-1:0] selection;
    logic [RowsW-1:0] window;
  } nav_state_t;

  // transition steps as 2-bit two's complement: 0, +1 (01), -1 (11)
  localparam logic [1:0] QUAD_TABLE [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

endpackage

// ----- sv/emn_core.sv -----
// ----------------------------------------------------------------------------
// emn_core
// Next-state logic: decodes one request against the current navigation
// state and produces the updated state and the result fields.
// ----------------------------------------------------------------------------
module emn_core (
  input  emn_pkg::nav_state_t        state_i,
  input  emn_pkg::in_item_t          item_i,
  input  logic [emn_pkg::RowsW-1:0]  row_count_i,
  input  logic [emn_pkg::LinesW-1:0] menu_lines_i,
  output emn_pkg::nav_state_t        state_o,
  output emn_pkg::out_item_t         result_o
);
  import emn_pkg::*;

  logic [3:0]       tab_idx;
  logic [1:0]       step;
  logic             step_nz;
  logic [RowsW:0]   sel_inc;
  logic [RowsW-1:0] sel_up;
  logic [RowsW-1:0] sel_down;
  logic [RowsW-1:0] sel_new;
  logic             recompute;
  logic             changed;
  logic [RowsW-1:0] lim;
  logic [RowsW-1:0] win_new;
  logic [RowsW-1:0] win_out;
  logic             parity_new;
  logic [1:0]       ab_new;
  logic             par_new;

  assign tab_idx = {state_i.prev_ab, item_i.enc_b, item_i.enc_a};
  assign step    = QUAD_TABLE[tab_idx];
  assign step_nz = (step != 2'b00);

  // selection stays below the row count, so a +-1 wrap is one compare
  assign sel_inc = {1'b0, state_i.selection} + {{RowsW{1'b0}}, 1'b1};
  always_comb begin
    if (row_count_i == '0) begin
      sel_up   = '0;
      sel_down = '0;
    end else begin
      sel_up   = (sel_inc >= {1'b0, row_count_i}) ? '0 : sel_inc[RowsW-1:0];
      sel_down = (state_i.selection == '0) ? (row_count_i - 1'b1)
                                           : (state_i.selection - 1'b1);
    end
  end

  assign parity_new = ~state_i.parity;

  always_comb begin
    sel_new   = state_i.selection;
    recompute = 1'b0;
    changed   = 1'b0;
    ab_new    = state_i.prev_ab;
    par_new   = state_i.parity;
    unique case (item_i.command)
      CMD_ENC: begin
        ab_new = {item_i.enc_b, item_i.enc_a};
        if (step_nz) begin
          changed   = 1'b1;
          recompute = 1'b1;
          par_new   = parity_new;
          if (!parity_new) begin
            sel_new = step[1] ? sel_down : sel_up;
          end
        end
      end
      CMD_UP: begin
        changed   = 1'b1;
        recompute = 1'b1;
        sel_new   = sel_up;
      end
      CMD_DOWN: begin
        changed   = 1'b1;
        recompute = 1'b1;
        sel_new   = sel_down;
      end
      CMD_CLEAR: begin
        recompute = 1'b1;
        sel_new   = '0;
      end
      default: begin
        sel_new = state_i.selection;
      end
    endcase
  end

  // window: sel-1 clamped to rows-lines, zero when everything fits
  assign lim = row_count_i - {{(RowsW-LinesW){1'b0}}, menu_lines_i};
  always_comb begin
    win_new = '0;
    if (row_count_i > {{(RowsW-LinesW){1'b0}}, menu_lines_i}) begin
      if (sel_new >= 16'd2) begin
        win_new = sel_new - 1'b1;
      end
      if (sel_new > lim) begin
        win_new = lim;
      end
    end
  end

  assign win_out = recompute ? win_new : state_i.window;

  assign state_o = '{prev_ab: ab_new, parity: par_new, selection: sel_new, window: win_out};

  assign result_o.selected_line    = sel_new;
  assign result_o.first_line       = win_out;
  assign result_o.position_changed = changed;

endmodule

// ----- sv/encoder_menu_navigator_unit.sv -----
// ----------------------------------------------------------------------------
// encoder_menu_navigator_unit
// Menu cursor driven by quadrature encoder samples and button requests.
// Each accepted request yields one result in the next cycle; a new request is
// taken every cycle while the result register is empty or being drained, so
// sustained throughput is one request per clock unless the output stalls. All
// decode, wrap and window logic sits in a single pass between the state
// registers and the result register. Writing the row count (register 0) clears
// the selection and the window unless a request is accepted in that cycle.
// ----------------------------------------------------------------------------
module encoder_menu_navigator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  emn_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output emn_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [emn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [emn_pkg::CfgDatW-1:0]  cfg_data_i
);
  import emn_pkg::*;

  nav_state_t        state_q, state_d, core_state;
  out_item_t         core_result;
  out_item_t         out_data_q;
  logic              out_valid_q;
  logic [RowsW-1:0]  rows_q;
  logic [LinesW-1:0] lines_q;
  logic              in_accept;
  logic              cfg_write;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  emn_core u_core (
    .state_i      (state_q),
    .item_i       (in_data_i),
    .row_count_i  (rows_q),
    .menu_lines_i (lines_q),
    .state_o      (core_state),
    .result_o     (core_result)
  );

  always_comb begin
    state_d = state_q;
    if (in_accept) begin
      state_d = core_state;
    end else if (cfg_write && (cfg_index_i == REG_ROW_COUNT)) begin
      state_d.selection = '0;
      state_d.window    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
      rows_q      <= RowsW'(1);
      lines_q     <= LinesW'(4);
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index_i)
          REG_ROW_COUNT:  rows_q  <= cfg_data_i[RowsW-1:0];
          REG_LINE_COUNT: lines_q <= cfg_data_i[LinesW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_sel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_q != '0) |-> (state_q.selection < rows_q))
    else $error("selection outside menu rows");

  a_sel_zero_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rows_q == '0) |-> (state_q.selection == '0))
    else $error("selection nonzero with no menu rows");

  a_window_le_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.window <= state_q.selection)
    else $error("window start past selection");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (out_valid_q && (out_data_q.selected_line == state_q.selection)))
    else $error("accepted request left no matching result");
`endif

endmodule
